@@ rtl/sig_pkg.sv @@
// ---------------------------------------------------------------------------
// sig_pkg: shared types and constants for the slice index generator
// Holds the result status codes, the front-end state type and the command
// word that passes from the front end to the back end through the queue.
// ---------------------------------------------------------------------------
package sig_pkg;

  // Default upper bound on vector length and slice count
  localparam int MaxLenDefault = 64;

  // Index and count widths, fixed by the field widths of the ports
  localparam int LenW  = 7;
  localparam int IdxW  = 6;
  localparam int PosW  = 8;   // signed position, -128 .. 127
  localparam int DivSteps = LenW;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_ZERO_STEP = 2'd2
  } status_t;

  // Front-end sequencer states
  typedef enum logic [1:0] {
    F_IDLE,
    F_NORM,
    F_DIV,
    F_PUSH
  } front_state_t;

  // Normalized request handed to the back end
  typedef struct packed {
    status_t                 status;
    logic [LenW-1:0]         start_idx;
    logic signed [PosW-1:0]  step;
    logic [LenW-1:0]         count;
  } cmd_t;

endpackage

@@ rtl/slice_index_generator_core.sv @@
// ---------------------------------------------------------------------------
// slice_index_generator_core: slice normalization and index generation
// Throughput: one index word per cycle while out_ready is high; the front end
// takes no new request until it has pushed the last one, running its 7-step
// serial count divider (skipped for a status-only request), and the emitter
// and front end overlap through the queue.
// Reset (synchronous, active high) empties the queue and drops any request.
// ---------------------------------------------------------------------------
module slice_index_generator_core #(
  parameter int MAX_LEN = sig_pkg::MaxLenDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [6:0]         vec_length,
  input  logic signed [31:0] slice_start,
  input  logic signed [31:0] slice_stop,
  input  logic signed [31:0] slice_step,
  input  logic [2:0]         given_mask,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         source_index,
  output logic               is_last,
  output logic [1:0]         status,
  output logic [6:0]         slice_count
);
  import sig_pkg::*;

  cmd_t f_cmd, b_cmd;
  logic f_valid, f_ready, b_valid, b_ready;

  // request front end
  sig_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .vec_length  (vec_length),
    .slice_start (slice_start),
    .slice_stop  (slice_stop),
    .slice_step  (slice_step),
    .given_mask  (given_mask),
    .cmd_valid   (f_valid),
    .cmd_ready   (f_ready),
    .cmd         (f_cmd)
  );

  // command queue
  sig_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_cmd),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_cmd)
  );

  // index emitter
  sig_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (b_valid),
    .cmd_ready    (b_ready),
    .cmd          (b_cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .source_index (source_index),
    .is_last      (is_last),
    .status       (status),
    .slice_count  (slice_count)
  );

endmodule

@@ rtl/sig_front.sv @@
// ---------------------------------------------------------------------------
// sig_front: request capture, normalization and count division
// Captures a request word, wraps and clamps start/stop, then finds the
// element count with a bit-serial restoring divider and pushes a command.
// ---------------------------------------------------------------------------
module sig_front #(
  parameter int MAX_LEN = sig_pkg::MaxLenDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [6:0]         vec_length,
  input  logic signed [31:0] slice_start,
  input  logic signed [31:0] slice_stop,
  input  logic signed [31:0] slice_step,
  input  logic [2:0]         given_mask,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output sig_pkg::cmd_t      cmd
);
  import sig_pkg::*;

  localparam logic [31:0] MaxLenW = 32'(MAX_LEN);

  front_state_t state, state_next;

  // captured request
  logic [LenW-1:0]    len_r;
  logic signed [31:0] start_r;
  logic signed [31:0] stop_r;
  logic signed [31:0] step_r;
  logic [1:0]         given_r;

  // normalized request and divider
  status_t                status_r, status_next;
  logic signed [PosW-1:0] nstart;
  logic signed [PosW-1:0] step8;
  logic [LenW-1:0]        divisor;
  logic [LenW-1:0]        rem;
  logic [LenW-1:0]        quo;
  logic [2:0]             iter;

  // Wrap a negative position from the end, clamp out-of-range ones
  function automatic logic signed [PosW-1:0] norm_pos(
    input logic signed [31:0] v,
    input logic [LenW-1:0]    len,
    input logic               neg
  );
    logic signed [32:0]     sum;
    logic signed [31:0]     len32;
    logic signed [PosW-1:0] len8;
    logic signed [PosW-1:0] res;
    len32 = $signed({25'b0, len});
    len8  = $signed({1'b0, len});
    sum   = 33'(v) + 33'(len32);
    if (v < 0) begin
      if (sum < 0) res = neg ? -8'sd1 : 8'sd0;
      else         res = $signed(sum[PosW-1:0]);
    end else if (v >= len32) begin
      res = neg ? len8 - 8'sd1 : len8;
    end else begin
      res = $signed(v[PosW-1:0]);
    end
    return res;
  endfunction

  // Normalization (combinational, used in F_NORM)
  logic                   neg;
  logic signed [PosW-1:0] ns_start, ns_stop, len8;
  logic signed [PosW:0]   span;
  logic [31:0]            step_mag;
  logic [LenW-1:0]        step7;
  logic [LenW:0]          span_m1;

  always_comb begin
    neg      = step_r < 0;
    len8     = $signed({1'b0, len_r});
    if (given_r[0]) ns_start = norm_pos(start_r, len_r, neg);
    else            ns_start = neg ? len8 - 8'sd1 : 8'sd0;
    if (given_r[1]) ns_stop = norm_pos(stop_r, len_r, neg);
    else            ns_stop = neg ? -8'sd1 : len8;
    span     = neg ? (9'(ns_start) - 9'(ns_stop)) : (9'(ns_stop) - 9'(ns_start));
    step_mag = neg ? (~step_r + 32'd1) : step_r;
    step7    = (step_mag > 32'd127) ? 7'd127 : step_mag[LenW-1:0];
    span_m1  = span[LenW:0] - 8'd1;
    if (step_r == 0)    status_next = ST_ZERO_STEP;
    else if (span <= 0) status_next = ST_EMPTY;
    else                status_next = ST_OK;
  end

  // One restoring division step
  logic [LenW:0]   trial;
  logic            fits;
  always_comb begin
    trial = {rem, quo[LenW-1]};
    fits  = trial >= {1'b0, divisor};
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (in_valid) state_next = F_NORM;
      F_NORM: state_next = (status_next == ST_OK) ? F_DIV : F_PUSH;
      F_DIV:  if (iter == 3'(DivSteps - 1)) state_next = F_PUSH;
      F_PUSH: if (cmd_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // Outputs
  logic [LenW-1:0] count_raw;
  always_comb begin
    in_ready  = 1'b0;
    cmd_valid = 1'b0;
    case (state)
      F_IDLE:  in_ready  = 1'b1;
      F_PUSH:  cmd_valid = 1'b1;
      default: ;
    endcase
    count_raw     = quo + 7'd1;
    cmd.status    = status_r;
    cmd.start_idx = nstart[LenW-1:0];
    cmd.step      = step8;
    if (status_r != ST_OK)                   cmd.count = '0;
    else if ({25'b0, count_raw} > MaxLenW)   cmd.count = MaxLenW[LenW-1:0];
    else                                     cmd.count = count_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else     state <= state_next;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (in_valid) begin
          len_r   <= ({25'b0, vec_length} > MaxLenW) ? MaxLenW[LenW-1:0] : vec_length;
          start_r <= slice_start;
          stop_r  <= slice_stop;
          step_r  <= given_mask[2] ? slice_step : 32'sd1;
          given_r <= given_mask[1:0];
        end
      end
      F_NORM: begin
        status_r <= status_next;
        nstart   <= ns_start;
        step8    <= neg ? -$signed({1'b0, step7}) : $signed({1'b0, step7});
        divisor  <= step7;
        rem      <= '0;
        quo      <= span_m1[LenW-1:0];
        iter     <= '0;
      end
      F_DIV: begin
        rem  <= fits ? 7'(trial - {1'b0, divisor}) : trial[LenW-1:0];
        quo  <= {quo[LenW-2:0], fits};
        iter <= iter + 3'd1;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/sig_queue.sv @@
// ---------------------------------------------------------------------------
// sig_queue: two-entry command queue
// Decouples the front end from the back end so each can stall on its own.
// ---------------------------------------------------------------------------
module sig_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  sig_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output sig_pkg::cmd_t rd_data
);
  import sig_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       push, pop;

  assign wr_ready = fill != 2'd2;
  assign rd_valid = fill != 2'd0;
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/sig_back.sv @@
// ---------------------------------------------------------------------------
// sig_back: index emitter
// Walks a normalized command into an output register, one index word per
// cycle unless out_ready stalls it; status-only commands give a single word.
// ---------------------------------------------------------------------------
module sig_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  sig_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [5:0]    source_index,
  output logic          is_last,
  output logic [1:0]    status,
  output logic [6:0]    slice_count
);
  import sig_pkg::*;

  logic                   active;
  logic [PosW-1:0]        idx;
  logic signed [PosW-1:0] step;
  logic [LenW-1:0]        pos;
  logic [LenW-1:0]        count;
  logic                   adv;
  logic                   first_last;
  logic                   run_last;

  assign adv        = !out_valid || out_ready;
  assign cmd_ready  = adv && !active;
  assign first_last = (cmd.status != ST_OK) || (cmd.count <= 7'd1);
  assign run_last   = pos == (count - 7'd1);

  // walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      if (active) begin
        out_valid <= 1'b1;
        if (run_last) active <= 1'b0;
      end else begin
        out_valid <= cmd_valid;
        if (cmd_valid && !first_last) active <= 1'b1;
      end
    end
  end

  // output word and walk datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      if (active) begin
        source_index <= idx[IdxW-1:0];
        is_last      <= run_last;
        status       <= ST_OK;
        slice_count  <= count;
        idx          <= idx + step;
        pos          <= pos + 7'd1;
      end else if (cmd_valid) begin
        source_index <= (cmd.status == ST_OK) ? cmd.start_idx[IdxW-1:0] : '0;
        is_last      <= first_last;
        status       <= cmd.status;
        slice_count  <= cmd.count;
        idx          <= {1'b0, cmd.start_idx} + cmd.step;
        step         <= cmd.step;
        count        <= cmd.count;
        pos          <= 7'd1;
      end
    end
  end

endmodule

@@ bench/tb_slice_index_generator_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_slice_index_generator_core: self-checking bench for the slice index core
// Drives slice requests through the valid/ready input and checks every index
// word against a built-in model of slice normalization. A directed table
// covers field extremes, zero step, empty slices and length saturation.
// Random requests follow, with random gaps and stalls on both sides, one
// long output hold-off and one drain pause.
// ---------------------------------------------------------------------------
module tb_slice_index_generator_core;
  import sig_pkg::*;

  localparam int MAX_LEN = sig_pkg::MaxLenDefault;
  localparam int RANDOM_REQS = 350;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam longint CYCLE_LIMIT = 4_000_000;

  // given_mask bits
  localparam logic [2:0] START_GIVEN = 3'b001;
  localparam logic [2:0] STOP_GIVEN  = 3'b010;
  localparam logic [2:0] STEP_GIVEN  = 3'b100;
  localparam logic [2:0] ALL_GIVEN   = 3'b111;

  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic [6:0]         len;
    logic signed [31:0] start;
    logic signed [31:0] stop;
    logic signed [31:0] step;
    logic [2:0]         mask;
  } slice_req_t;

  typedef struct {
    logic [5:0] idx;
    logic       last;
    status_t    st;
    logic [6:0] cnt;
  } index_word_t;

  // Directed row: a typed row expects a single status word
  typedef struct {
    slice_req_t req;
    bit         typed;
    status_t    st;
  } directed_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [6:0]         vec_length = '0;
  logic signed [31:0] slice_start = '0;
  logic signed [31:0] slice_stop = '0;
  logic signed [31:0] slice_step = '0;
  logic [2:0]         given_mask = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [5:0]         source_index;
  logic               is_last;
  logic [1:0]         status;
  logic [6:0]         slice_count;

  index_word_t   expected_words[$];
  directed_row_t directed_rows[$];
  int            mismatches = 0;
  longint        cycle_count = 0;
  logic          hold_req = 1'b0;
  logic          hold_active = 1'b0;

  slice_index_generator_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .vec_length   (vec_length),
    .slice_start  (slice_start),
    .slice_stop   (slice_stop),
    .slice_step   (slice_step),
    .given_mask   (given_mask),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .source_index (source_index),
    .is_last      (is_last),
    .status       (status),
    .slice_count  (slice_count)
  );

  // Clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Wrap a negative position from the end, clamp out-of-range ones
  function automatic longint wrap_clamp(input longint pos, input longint n,
                                        input longint lo, input longint hi);
    if (pos < 0) begin
      pos = pos + n;
      if (pos < 0) pos = lo;
    end else if (pos >= n) begin
      pos = hi;
    end
    return pos;
  endfunction

  function automatic index_word_t status_word(input status_t st);
    index_word_t w;
    w.idx  = '0;
    w.last = 1'b1;
    w.st   = st;
    w.cnt  = '0;
    return w;
  endfunction

  // Normalize one request and queue the index words it should produce
  function automatic void predict_slice(input slice_req_t r);
    longint n, stride, lo, hi, first, bound, cnt, pos, k;
    index_word_t w;
    n = r.len;
    if (n > MAX_LEN) n = MAX_LEN;
    stride = r.mask[2] ? longint'(r.step) : 1;
    if (stride == 0) begin
      expected_words.push_back(status_word(ST_ZERO_STEP));
      return;
    end
    lo = (stride < 0) ? -1 : 0;
    hi = (stride < 0) ? n - 1 : n;
    if (r.mask[0]) first = wrap_clamp(longint'(r.start), n, lo, hi);
    else           first = (stride < 0) ? n - 1 : 0;
    if (r.mask[1]) bound = wrap_clamp(longint'(r.stop), n, lo, hi);
    else           bound = (stride < 0) ? -1 : n;
    if (stride > 0)
      cnt = (bound > first) ? (bound - first + stride - 1) / stride : 0;
    else
      cnt = (first > bound) ? (first - bound - stride - 1) / (-stride) : 0;
    if (cnt <= 0) begin
      expected_words.push_back(status_word(ST_EMPTY));
      return;
    end
    if (cnt > MAX_LEN) cnt = MAX_LEN;
    pos = first;
    for (k = 0; k < cnt; k++) begin
      w.idx  = pos[5:0];
      w.last = (k == cnt - 1);
      w.st   = ST_OK;
      w.cnt  = cnt[6:0];
      expected_words.push_back(w);
      pos = pos + stride;
    end
  endfunction

  function automatic void add_row(input logic [6:0] len, input logic signed [31:0] start,
                                  input logic signed [31:0] stop,
                                  input logic signed [31:0] step, input logic [2:0] mask,
                                  input bit typed, input status_t st);
    directed_row_t row;
    row.req.len   = len;
    row.req.start = start;
    row.req.stop  = stop;
    row.req.step  = step;
    row.req.mask  = mask;
    row.typed     = typed;
    row.st        = st;
    directed_rows.push_back(row);
  endfunction

  // Mostly small, well-formed values with occasional full-range ones
  function automatic logic signed [31:0] random_pos();
    if ($urandom_range(0, 99) < 85) return 32'(int'($urandom_range(0, 160)) - 80);
    return $urandom;
  endfunction

  function automatic slice_req_t random_req();
    slice_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)      r.len = 7'($urandom_range(0, 20));
    else if (pick < 85) r.len = 7'($urandom_range(21, 64));
    else                r.len = 7'($urandom_range(65, 127));
    r.start = random_pos();
    r.stop  = random_pos();
    pick = $urandom_range(0, 99);
    if (pick < 70)      r.step = 32'(int'($urandom_range(1, 4)));
    else if (pick < 80) r.step = 32'(int'($urandom_range(5, 70)));
    else if (pick < 85) r.step = '0;
    else                r.step = $urandom;
    if (pick < 80 && $urandom_range(0, 1) == 1) r.step = -r.step;
    r.mask = 3'($urandom_range(0, 7));
    return r;
  endfunction

  // Offer one request after a random gap; queue its words on acceptance
  task automatic send_request(input slice_req_t r, input bit typed, input status_t st);
    int gap, pick;
    pick = $urandom_range(0, 99);
    if (hold_req || hold_active) gap = 0;
    else if (pick < 55)          gap = 0;
    else if (pick < 90)          gap = $urandom_range(1, 3);
    else                         gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    vec_length  <= r.len;
    slice_start <= r.start;
    slice_stop  <= r.stop;
    slice_step  <= r.step;
    given_mask  <= r.mask;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed) expected_words.push_back(status_word(st));
    else       predict_slice(r);
  endtask

  // Stimulus: directed table, then random requests
  initial begin : stimulus
    int k;
    slice_req_t r;
    // empty vector, zero step, zero step on an empty vector
    add_row(0, 0, 0, 0, 3'b000, 1, ST_EMPTY);
    add_row(10, 3, 7, 0, ALL_GIVEN, 1, ST_ZERO_STEP);
    add_row(0, 0, 0, 0, STEP_GIVEN, 1, ST_ZERO_STEP);
    // full length, saturated length, reverse walk
    add_row(64, 0, 0, 0, 3'b000, 0, ST_OK);
    add_row(127, S32_MAX, S32_MIN, 0, 3'b000, 0, ST_OK);
    add_row(65, 0, 0, 0, 3'b000, 0, ST_OK);
    add_row(1, 0, 0, 0, 3'b000, 0, ST_OK);
    add_row(64, 0, 0, -1, STEP_GIVEN, 0, ST_OK);
    // wrap and clamp of start and stop
    add_row(10, -1, 0, 0, START_GIVEN, 0, ST_OK);
    add_row(64, S32_MIN, S32_MAX, 1, ALL_GIVEN, 0, ST_OK);
    add_row(64, S32_MAX, S32_MIN, -1, ALL_GIVEN, 0, ST_OK);
    add_row(64, -64, 64, 1, ALL_GIVEN, 0, ST_OK);
    add_row(64, 100, -100, -7, ALL_GIVEN, 0, ST_OK);
    add_row(20, -3, S32_MIN, -2, ALL_GIVEN, 0, ST_OK);
    add_row(1, 5, -5, -1, ALL_GIVEN, 0, ST_OK);
    // extreme steps
    add_row(64, 0, 0, S32_MAX, STEP_GIVEN, 0, ST_OK);
    add_row(64, 0, 0, S32_MIN, STEP_GIVEN, 0, ST_OK);
    add_row(10, 0, 0, 3, STEP_GIVEN, 0, ST_OK);
    // step omitted: a zero step value is ignored
    add_row(20, 5, 15, 0, START_GIVEN | STOP_GIVEN, 0, ST_OK);
    // omitted start/stop ignore their values
    add_row(20, S32_MIN, 12, 2, STOP_GIVEN | STEP_GIVEN, 0, ST_OK);
    add_row(20, 4, S32_MIN, -3, START_GIVEN | STEP_GIVEN, 0, ST_OK);
    // empty slices from crossed bounds
    add_row(20, 7, 3, 1, ALL_GIVEN, 1, ST_EMPTY);
    add_row(20, 3, 7, -1, ALL_GIVEN, 1, ST_EMPTY);
    add_row(10, S32_MIN, 0, -1, START_GIVEN | STEP_GIVEN, 1, ST_EMPTY);

    @(posedge clk);
    while (rst) @(posedge clk);

    foreach (directed_rows[k])
      send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].st);

    for (k = 0; k < RANDOM_REQS; k++) begin
      // sender pause: let the block drain completely
      if (k == 120) begin
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
      end
      // receiver hold-off while requests keep coming
      if (k == 200) hold_req = 1'b1;
      r = random_req();
      send_request(r, 1'b0, ST_OK);
    end
    in_valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else                 $display("*** FAILED ***");
    $finish;
  end

  // Output side: free stretches, short and long stalls, one long hold-off
  initial begin : receiver
    int stall_left, free_left, pick;
    stall_left = 0;
    free_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_active = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req    = 1'b0;
        hold_active = 1'b0;
        stall_left  = 0;
        free_left   = 0;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (free_left > 0) begin
        free_left--;
        out_ready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10)      free_left  = $urandom_range(30, 100);
        else if (pick < 15) stall_left = $urandom_range(15, 40);
        else if (pick < 55) stall_left = $urandom_range(1, 3);
        out_ready <= (pick < 10 || pick >= 55);
      end
    end
  end

  // Compare each accepted word with the oldest expected one
  always @(posedge clk) begin : check_words
    index_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: source_index %0d status %0d slice_count %0d",
               source_index, status, slice_count);
        mismatches++;
      end else begin
        w = expected_words.pop_front();
        if (source_index !== w.idx) begin
          $error("source_index: expected %0d, got %0d", w.idx, source_index);
          mismatches++;
        end
        if (is_last !== w.last) begin
          $error("is_last: expected %0d, got %0d", w.last, is_last);
          mismatches++;
        end
        if (status !== w.st) begin
          $error("status: expected %0d, got %0d", w.st, status);
          mismatches++;
        end
        if (slice_count !== w.cnt) begin
          $error("slice_count: expected %0d, got %0d", w.cnt, slice_count);
          mismatches++;
        end
      end
    end
  end

endmodule
